[design/prl_pkg.sv]
// prl_pkg: shared types and constants of the positional record list
// holds store geometry, operation and status codes, transaction structs
// no dependencies
`default_nettype none

package prl_pkg;

  // store geometry
  localparam int DEPTH  = 128;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = CNT_W + 9;
  localparam int KEY_W  = 64;
  localparam int NAME_W = 64;
  localparam int REC_W  = KEY_W + NAME_W;

  localparam logic [7:0] CAP_RESET = 8'd5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // input transaction
  typedef struct packed {
    op_t                operation;
    logic [7:0]         position;
    logic [KEY_W-1:0]   entry_id;
    logic [NAME_W-1:0]  entry_name;
  } in_t;

  // result transaction
  typedef struct packed {
    status_t    status;
    logic [6:0] found_index;
    logic [7:0] item_count;
  } out_t;

endpackage

`default_nettype wire

[design/prl_ram.sv]
// prl_ram: generic single write port, single read port memory
// read data is registered; no reset on the array
// no dependencies
`default_nettype none

module prl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[design/positional_record_list.sv]
// positional_record_list: ordered record list with append, insert, delete, search
// uses prl_pkg for types and constants, prl_ram for the record store
// one sequencer drives a single read/write memory port pair
//
//   channel   direction  handshake          payload
//   in        input      in_valid/in_stall  in_data   (in_t)
//   out       output     out_valid/out_stall out_data (out_t)
//   cfg       input      cfg_we             cfg_wdata (list_capacity)
//
// append and rejected operations go straight to the done state; the result is
// loaded into the output register from there once it is free. insert and
// delete shift the tail of the list, search scans from the first entry;
// one entry is moved or compared per cycle through the single read/write port.
// synchronous reset clears the count, the capacity (to 5) and the sequencer;
// the store is not cleared. in_stall is high from acceptance until the
// result is loaded into the output register; a stalled result holds there.
`default_nettype none

module positional_record_list import prl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_t            out_data,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOVE = 5'b00010,
    S_SCAN = 5'b00100,
    S_FILL = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state;
  logic [7:0]          capacity;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    moves;
  logic [IDX_W-1:0]    rd_ptr;
  logic                pend;
  logic [IDX_W-1:0]    pend_addr;
  logic                shift_up;
  logic [IDX_W-1:0]    ins_idx;
  logic [REC_W-1:0]    new_rec;
  status_t             res_status;
  logic [IDX_W-1:0]    res_found;

  logic                accept;
  logic                out_free;
  logic [CMP_W-1:0]    pos_w;
  logic [CMP_W-1:0]    cnt_w;
  logic [CMP_W-1:0]    cap_w;
  logic                is_full;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [REC_W-1:0]    wr_data;
  logic [REC_W-1:0]    rd_data;
  logic                hit;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // common width views for range and capacity checks
  always_comb begin
    pos_w = CMP_W'(in_data.position);
    cnt_w = CMP_W'(count);
    cap_w = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity);
    is_full = (cnt_w >= cap_w);
  end

  assign hit = pend && (rd_data[REC_W-1 -: KEY_W] == new_rec[REC_W-1 -: KEY_W]);

  // store write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    case (state)
      S_IDLE: begin
        wr_en   = accept && (in_data.operation == OP_APPEND) && !is_full;
        wr_addr = IDX_W'(count);
        wr_data = {in_data.entry_id, in_data.entry_name};
      end
      S_MOVE: begin
        wr_en = pend;
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = ins_idx;
        wr_data = new_rec;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  prl_ram #(
    .WIDTH(REC_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_ptr),
    .rd_data(rd_data)
  );

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      moves      <= '0;
      rd_ptr     <= '0;
      pend       <= 1'b0;
      pend_addr  <= '0;
      shift_up   <= 1'b0;
      ins_idx    <= '0;
      res_status <= ST_OK;
      res_found  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            new_rec    <= {in_data.entry_id, in_data.entry_name};
            ins_idx    <= IDX_W'(pos_w - CMP_W'(1));
            res_status <= ST_OK;
            res_found  <= '0;
            pend       <= 1'b0;
            state      <= S_DONE;
            case (in_data.operation)
              OP_APPEND: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              OP_INSERT: begin
                if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
                  res_status <= ST_RANGE;
                end else if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  moves    <= CNT_W'(cnt_w - pos_w + CMP_W'(1));
                  rd_ptr   <= IDX_W'(cnt_w - CMP_W'(1));
                  shift_up <= 1'b1;
                  state    <= S_MOVE;
                end
              end
              OP_DELETE: begin
                if (pos_w == '0 || pos_w > cnt_w) begin
                  res_status <= ST_RANGE;
                end else begin
                  moves    <= CNT_W'(cnt_w - pos_w);
                  rd_ptr   <= IDX_W'(pos_w);
                  shift_up <= 1'b0;
                  count    <= count - CNT_W'(1);
                  state    <= S_MOVE;
                end
              end
              OP_SEARCH: begin
                moves    <= count;
                rd_ptr   <= '0;
                shift_up <= 1'b0;
                state    <= S_SCAN;
              end
              default: begin
                res_status <= ST_OK;
              end
            endcase
          end
        end
        // one entry read and one entry written per cycle
        S_MOVE: begin
          if (moves != '0) begin
            moves     <= moves - CNT_W'(1);
            pend      <= 1'b1;
            pend_addr <= shift_up ? rd_ptr + IDX_W'(1) : rd_ptr - IDX_W'(1);
            rd_ptr    <= shift_up ? rd_ptr - IDX_W'(1) : rd_ptr + IDX_W'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= shift_up ? S_FILL : S_DONE;
            end
          end
        end
        // one key compared per cycle, stop at first match
        S_SCAN: begin
          if (hit) begin
            res_found <= pend_addr;
            pend      <= 1'b0;
            state     <= S_DONE;
          end else if (moves == '0 && !pend) begin
            res_status <= ST_MISSING;
            state      <= S_DONE;
          end else begin
            pend <= (moves != '0);
            if (moves != '0) begin
              moves     <= moves - CNT_W'(1);
              pend_addr <= rd_ptr;
              rd_ptr    <= rd_ptr + IDX_W'(1);
            end
          end
        end
        // place the new record after the shift
        S_FILL: begin
          count <= count + CNT_W'(1);
          state <= S_DONE;
        end
        // hand the result to the output register when it is free
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data.status      <= res_status;
      out_data.found_index <= 7'(res_found);
      out_data.item_count  <= 8'(count);
    end
  end

  // count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(DEPTH))
    else $error("entry count beyond store depth");

  // an accepted transaction leaves the sequencer busy, so the input stalls after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken again right after acceptance");

  // shift never reads the entry it is writing
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) && pend && (moves != '0) |-> pend_addr != rd_ptr)
    else $error("shift read and write collide");

  // a result is only loaded from the final state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside the final state");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// tb_top: self-checking testbench for the positional record list
// keeps its own copy of the list to predict status, found index and count
// depends on prl_pkg and positional_record_list
`default_nettype none

module tb_top;
  import prl_pkg::*;

  // clock, reset and block ports
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  // operations waiting for the driver, results waiting for the monitor
  in_t  queued_ops[$];
  out_t due_results[$];
  int   queued_count  = 0;
  int   sent_count    = 0;
  int   mismatch_count = 0;
  bit   in_fire       = 1'b0;

  // idle and stall rates of the current phase, in percent
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // shadow copy of the list
  logic [KEY_W-1:0]  shadow_keys  [DEPTH];
  logic [NAME_W-1:0] shadow_names [DEPTH];
  int                shadow_count = 0;
  logic [7:0]        shadow_cap   = CAP_RESET;

  positional_record_list dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // apply one list operation to the shadow copy and return its result
  function automatic out_t apply_list_op(input in_t t);
    out_t r;
    int   lim;
    int   p;
    int   hit;
    int   i;
    lim = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
    p = int'(t.position);
    hit = -1;
    r.status = ST_OK;
    r.found_index = '0;
    case (t.operation)
      OP_APPEND: begin
        if (shadow_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          shadow_keys[shadow_count] = t.entry_id;
          shadow_names[shadow_count] = t.entry_name;
          shadow_count++;
        end
      end
      OP_INSERT: begin
        // position is checked before fullness
        if (p < 1 || p > shadow_count + 1) begin
          r.status = ST_RANGE;
        end else if (shadow_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > p - 1; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_names[i] = shadow_names[i-1];
          end
          shadow_keys[p-1] = t.entry_id;
          shadow_names[p-1] = t.entry_name;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p - 1; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_names[i] = shadow_names[i+1];
          end
          shadow_count--;
        end
      end
      default: begin
        // first matching key wins
        for (i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_keys[i] == t.entry_id) hit = i;
        end
        if (hit < 0) r.status = ST_MISSING;
        else r.found_index = 7'(hit);
      end
    endcase
    r.item_count = 8'(shadow_count);
    return r;
  endfunction

  // monitor: check results, then predict for the accepted transaction
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      in_fire = 1'b0;
      shadow_count = 0;
      shadow_cap = CAP_RESET;
    end else begin
      in_fire = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result: status %0d found %0d count %0d", $time,
                   out_data.status, out_data.found_index, out_data.item_count);
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status) begin
            mismatch_count++;
            $display("%0t status mismatch: expected %0d, actual %0d", $time,
                     want.status, out_data.status);
          end
          if (out_data.found_index !== want.found_index) begin
            mismatch_count++;
            $display("%0t found_index mismatch: expected %0d, actual %0d", $time,
                     want.found_index, out_data.found_index);
          end
          if (out_data.item_count !== want.item_count) begin
            mismatch_count++;
            $display("%0t item_count mismatch: expected %0d, actual %0d", $time,
                     want.item_count, out_data.item_count);
          end
        end
      end
      if (in_fire) begin
        due_results.push_back(apply_list_op(in_data));
        sent_count++;
      end
      if (cfg_we) shadow_cap = cfg_wdata;
    end
  end

  // driver: present queued transactions, hold a stalled one, random gaps and stalls
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (queued_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= queued_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic queue_op(input op_t op, input int pos, input logic [63:0] id,
                          input logic [63:0] nm);
    in_t t;
    t.operation = op;
    t.position = 8'(pos);
    t.entry_id = id;
    t.entry_name = nm;
    queued_ops.push_back(t);
    queued_count++;
  endtask

  // wait until every queued transaction has been accepted and answered
  task automatic drain_list();
    @(negedge clk);
    while (sent_count != queued_count || due_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [7:0] c);
    drain_list();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  localparam logic [63:0] KEY_POOL = 64'h4944_3030_3030_3030;
  localparam logic [63:0] KEY_A    = 64'h414C_5048_4130_3031;
  localparam logic [63:0] KEY_B    = 64'h4252_4156_4F30_3032;
  localparam logic [63:0] KEY_C    = 64'h4348_4152_4C49_4533;
  localparam logic [63:0] ALL_ONES = '1;

  // stimulus
  initial begin
    int          ph;
    int          k;
    int          n;
    int          r;
    int          cnt;
    int          pos;
    bit          grow;
    op_t         op;
    logic [63:0] id;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, boundaries, full list at reset capacity
    queue_op(OP_SEARCH, 0, 64'd0, 64'd0);
    queue_op(OP_DELETE, 1, 64'd0, 64'd0);
    queue_op(OP_DELETE, 0, 64'd0, 64'd0);
    queue_op(OP_INSERT, 0, KEY_A, ALL_ONES);
    queue_op(OP_INSERT, 2, KEY_A, ALL_ONES);
    queue_op(OP_INSERT, 1, KEY_A, ALL_ONES);
    queue_op(OP_APPEND, 0, 64'd0, 64'd0);
    queue_op(OP_APPEND, 255, ALL_ONES, ALL_ONES);
    queue_op(OP_INSERT, 1, KEY_B, 64'h0123_4567_89AB_CDEF);
    queue_op(OP_INSERT, 5, KEY_C, 64'hFEDC_BA98_7654_3210);
    queue_op(OP_APPEND, 0, KEY_B, 64'd0);
    queue_op(OP_INSERT, 3, KEY_B, 64'd0);
    queue_op(OP_INSERT, 7, KEY_B, 64'd0);
    queue_op(OP_INSERT, 255, KEY_B, 64'd0);
    queue_op(OP_SEARCH, 0, ALL_ONES, 64'd0);
    queue_op(OP_SEARCH, 0, KEY_C, 64'd0);
    queue_op(OP_SEARCH, 0, KEY_POOL, 64'd0);
    queue_op(OP_DELETE, 255, 64'd0, 64'd0);
    queue_op(OP_DELETE, 6, 64'd0, 64'd0);
    queue_op(OP_DELETE, 5, 64'd0, 64'd0);
    queue_op(OP_DELETE, 1, 64'd0, 64'd0);
    queue_op(OP_APPEND, 0, KEY_A, 64'd0);
    queue_op(OP_SEARCH, 0, KEY_A, 64'd0);

    // capacity lowered below the current count
    set_capacity(8'd2);
    queue_op(OP_APPEND, 0, KEY_C, 64'd0);
    queue_op(OP_INSERT, 2, KEY_C, 64'd0);
    queue_op(OP_DELETE, 2, 64'd0, 64'd0);
    queue_op(OP_SEARCH, 0, ALL_ONES, 64'd0);

    // random phases, each with its own capacity and one of four idle and stall patterns
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_capacity(8'd8);
        1: set_capacity(8'd1);
        2: set_capacity(8'd128);
        3: set_capacity(8'd0);
        4: set_capacity(8'd16);
        5: set_capacity(8'd255);
        6: set_capacity(8'd3);
        default: set_capacity(8'd40);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase

      // fill to the largest size once
      if (ph == 2) begin
        n = DEPTH - shadow_count;
        for (k = 0; k < n; k++) queue_op(OP_APPEND, $urandom_range(0, 255),
                                          {$urandom, $urandom}, {$urandom, $urandom});
      end

      for (k = 0; k < 140; k++) begin
        while (queued_ops.size() != 0) @(negedge clk);
        if ($urandom_range(0, 99) == 0) drain_list();
        grow = ((k / 35) % 2) == 0;
        cnt = shadow_count;

        // operation mix leans toward growth or shrinkage
        r = $urandom_range(0, 99);
        if (grow) begin
          op = (r < 35) ? OP_APPEND : (r < 70) ? OP_INSERT : (r < 80) ? OP_DELETE : OP_SEARCH;
        end else begin
          op = (r < 10) ? OP_APPEND : (r < 20) ? OP_INSERT : (r < 80) ? OP_DELETE : OP_SEARCH;
        end

        // mostly legal positions, some out of range
        r = $urandom_range(0, 99);
        if (r < 6) pos = 0;
        else if (r < 10) pos = 255;
        else if (r < 16) pos = $urandom_range(0, 255);
        else if (op == OP_DELETE) pos = (cnt == 0) ? 1 : $urandom_range(1, cnt);
        else pos = $urandom_range(1, cnt + 1);

        // searches mostly look for stored keys, pool keys give duplicates
        r = $urandom_range(0, 99);
        if (op == OP_SEARCH && cnt != 0 && r < 60) begin
          id = shadow_keys[$urandom_range(0, cnt - 1)];
        end else if (r < 30 || (op == OP_SEARCH && r < 80)) begin
          id = KEY_POOL + 64'($urandom_range(0, 7));
        end else begin
          id = {$urandom, $urandom};
        end
        queue_op(op, pos, id, {$urandom, $urandom});
      end
    end

    drain_list();
    repeat (DEPTH + 8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
